### rtl/orv_pkg.sv
package orv_pkg;

  // item function codes
  localparam logic [2:0] FN_BEGIN  = 3'd0;
  localparam logic [2:0] FN_HEADER = 3'd1;
  localparam logic [2:0] FN_DATA   = 3'd2;
  localparam logic [2:0] FN_END    = 3'd3;
  localparam logic [2:0] FN_REBOOT = 3'd4;

  // result status codes
  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_TOO_BIG     = 4'd1;
  localparam logic [3:0] ST_CHUNK_IDLE  = 4'd2;
  localparam logic [3:0] ST_BAD_LENGTH  = 4'd3;
  localparam logic [3:0] ST_OFFSET_SKEW = 4'd4;
  localparam logic [3:0] ST_END_IDLE    = 4'd5;
  localparam logic [3:0] ST_SIZE_MISM   = 4'd6;
  localparam logic [3:0] ST_DIGEST_MISM = 4'd7;
  localparam logic [3:0] ST_NOT_FINAL   = 4'd8;

  // session modes
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_RECV  = 2'd1;
  localparam logic [1:0] MODE_FINAL = 2'd2;
  localparam logic [1:0] MODE_ERROR = 2'd3;

  localparam logic [23:0] MAX_SIZE_RESET = 24'd1048576;
  localparam logic [7:0]  PAD_BYTE       = 8'h80;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ROUND = 4'b0010,
    S_FOLD  = 4'b0100,
    S_CHECK = 4'b1000
  } seq_state_t;

  typedef logic [31:0] word_t;

  // sha-256 initial hash value
  function automatic word_t hash_init(input logic [2:0] idx);
    word_t r;
    case (idx)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  // sha-256 round constants
  function automatic word_t round_k(input logic [5:0] idx);
    word_t r;
    case (idx)
      6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;  6'd2: r = 32'hb5c0fbcf;
      6'd3: r = 32'he9b5dba5;  6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
      6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;  6'd8: r = 32'hd807aa98;
      6'd9: r = 32'h12835b01;  6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
      6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
      6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
      6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
      6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
      6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
      6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
      6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
      6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
      default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

endpackage

### rtl/ota_image_receive_verifier_unit.sv
// begin (on digest word 3), header-reject, end-reject, reboot and non-block-closing data
//   items give their result in the cycle after acceptance
// a data byte that closes a 64-byte block holds the input through the rounds and the fold
//   (S_ROUND, S_FOLD); an end item hashes one or two padded blocks, then runs S_CHECK
// throughput: one item per cycle while in_stall is low (round unit idle, no held result)
// reset: rst_n synchronous active low, clears session state and loads the initial hash
module ota_image_receive_verifier_unit import orv_pkg::*; #(
  parameter int MAX_CHUNK_BYTES = 256,
  parameter int SIZE_BITS       = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_func,
  input  logic [23:0] in_image_size,
  input  logic [1:0]  in_digest_index,
  input  logic [63:0] in_digest_word,
  input  logic [23:0] in_chunk_offset,
  input  logic [8:0]  in_chunk_length,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_status,
  output logic [23:0] out_echo_offset,
  output logic        out_swap_request
);

  seq_state_t           state_r;
  logic [1:0]           mode_r;
  logic [23:0]          max_size_r;
  logic [SIZE_BITS-1:0] decl_r;
  logic [SIZE_BITS-1:0] cnt_r;
  logic [8:0]           rem_r;
  logic [23:0]          cur_off_r;
  word_t                h_r [8];
  word_t                v_r [8];
  word_t                blk_r [16];
  logic [63:0]          dig_r [4];
  logic [5:0]           rnd_r;
  logic                 second_r;
  logic                 is_end_r;
  logic                 resp_r;
  logic [23:0]          resp_echo_r;
  logic                 out_valid_r;
  logic [3:0]           out_status_r;
  logic [23:0]          out_echo_r;
  logic                 out_swap_r;

  logic                 accept;
  logic [31:0]          size_ext;
  logic [31:0]          off_ext;
  logic [SIZE_BITS-1:0] size_m;
  logic [SIZE_BITS-1:0] off_m;
  logic [31:0]          off_back;
  logic [5:0]           fill;
  logic [63:0]          len_bits;
  word_t                pad_w [16];
  word_t                hsum [8];
  logic [8:0]           rem_dec;
  logic                 len_bad;
  logic                 digest_ok;

  // round unit signals
  word_t e1, ch, t1, a0, mj, s0, s1, w_new;

  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_echo_offset  = out_echo_r;
  assign out_swap_request = out_swap_r;

  // field masking to the counter width
  assign size_ext = {8'd0, in_image_size};
  assign off_ext  = {8'd0, in_chunk_offset};
  assign size_m   = size_ext[SIZE_BITS-1:0];
  assign off_m    = off_ext[SIZE_BITS-1:0];
  assign off_back = 32'(off_m);
  assign rem_dec  = rem_r - 9'd1;
  assign len_bad  = (in_chunk_length == 9'd0) ||
                    (32'(in_chunk_length) > 32'(MAX_CHUNK_BYTES));

  // message padding
  assign fill     = cnt_r[5:0];
  assign len_bits = 64'({cnt_r, 3'b000});

  always_comb begin
    for (int j = 0; j < 16; j++) begin
      for (int l = 0; l < 4; l++) begin
        if (6'(4 * j + l) < fill) begin
          pad_w[j][31-8*l -: 8] = blk_r[j][31-8*l -: 8];
        end else if (6'(4 * j + l) == fill) begin
          pad_w[j][31-8*l -: 8] = PAD_BYTE;
        end else begin
          pad_w[j][31-8*l -: 8] = 8'd0;
        end
      end
    end
  end

  // shared sha-256 round and schedule step
  always_comb begin
    e1 = {v_r[4][5:0], v_r[4][31:6]} ^ {v_r[4][10:0], v_r[4][31:11]} ^
         {v_r[4][24:0], v_r[4][31:25]};
    ch = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1 = v_r[7] + e1 + ch + round_k(rnd_r) + blk_r[0];
    a0 = {v_r[0][1:0], v_r[0][31:2]} ^ {v_r[0][12:0], v_r[0][31:13]} ^
         {v_r[0][21:0], v_r[0][31:22]};
    mj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    s0 = {blk_r[1][6:0], blk_r[1][31:7]} ^ {blk_r[1][17:0], blk_r[1][31:18]} ^
         (blk_r[1] >> 3);
    s1 = {blk_r[14][16:0], blk_r[14][31:17]} ^ {blk_r[14][18:0], blk_r[14][31:19]} ^
         (blk_r[14] >> 10);
    w_new = blk_r[0] + s0 + blk_r[9] + s1;
  end

  // chaining value fold
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      hsum[i] = h_r[i] + v_r[i];
    end
  end

  // digest compare
  assign digest_ok = ({h_r[0], h_r[1]} == dig_r[0]) && ({h_r[2], h_r[3]} == dig_r[1]) &&
                     ({h_r[4], h_r[5]} == dig_r[2]) && ({h_r[6], h_r[7]} == dig_r[3]);

  // sequencer and session state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_IDLE;
      max_size_r  <= MAX_SIZE_RESET;
      decl_r      <= '0;
      cnt_r       <= '0;
      rem_r       <= '0;
      cur_off_r   <= '0;
      rnd_r       <= '0;
      second_r    <= 1'b0;
      is_end_r    <= 1'b0;
      resp_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= hash_init(3'(i));
      end
    end else begin
      if (cfg_we) begin
        max_size_r <= cfg_wdata;
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            out_status_r <= ST_OK;
            out_echo_r   <= '0;
            out_swap_r   <= 1'b0;
            case (in_func)
              FN_BEGIN: begin
                dig_r[in_digest_index] <= in_digest_word;
                if (in_digest_index == 2'd3) begin
                  out_valid_r <= 1'b1;
                  if (in_image_size > max_size_r) begin
                    out_status_r <= ST_TOO_BIG;
                  end else begin
                    mode_r    <= MODE_RECV;
                    decl_r    <= size_m;
                    cnt_r     <= '0;
                    rem_r     <= '0;
                    cur_off_r <= '0;
                    for (int i = 0; i < 8; i++) begin
                      h_r[i] <= hash_init(3'(i));
                    end
                  end
                end
              end
              FN_HEADER: begin
                if (mode_r != MODE_RECV) begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= ST_CHUNK_IDLE;
                end else if (len_bad) begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= ST_BAD_LENGTH;
                end else if (off_m != cnt_r) begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= ST_OFFSET_SKEW;
                end else begin
                  rem_r     <= in_chunk_length;
                  cur_off_r <= off_back[23:0];
                end
              end
              FN_DATA: begin
                if (mode_r == MODE_RECV && rem_r != 9'd0) begin
                  blk_r[fill[5:2]][31-8*fill[1:0] -: 8] <= in_data_byte;
                  cnt_r <= cnt_r + 1'b1;
                  rem_r <= rem_dec;
                  if (fill == 6'd63) begin
                    // block complete: run the compression
                    state_r     <= S_ROUND;
                    rnd_r       <= '0;
                    second_r    <= 1'b0;
                    is_end_r    <= 1'b0;
                    resp_r      <= (rem_dec == 9'd0);
                    resp_echo_r <= cur_off_r;
                    for (int i = 0; i < 8; i++) begin
                      v_r[i] <= h_r[i];
                    end
                  end else if (rem_dec == 9'd0) begin
                    out_valid_r <= 1'b1;
                    out_echo_r  <= cur_off_r;
                  end
                end
              end
              FN_END: begin
                if (mode_r != MODE_RECV) begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= ST_END_IDLE;
                end else if (cnt_r != decl_r) begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= ST_SIZE_MISM;
                  mode_r       <= MODE_ERROR;
                  rem_r        <= '0;
                end else begin
                  // pad and hash the final block or blocks
                  for (int j = 0; j < 14; j++) begin
                    blk_r[j] <= pad_w[j];
                  end
                  if (fill >= 6'd56) begin
                    blk_r[14] <= pad_w[14];
                    blk_r[15] <= pad_w[15];
                    second_r  <= 1'b1;
                  end else begin
                    blk_r[14] <= len_bits[63:32];
                    blk_r[15] <= len_bits[31:0];
                    second_r  <= 1'b0;
                  end
                  state_r  <= S_ROUND;
                  rnd_r    <= '0;
                  is_end_r <= 1'b1;
                  resp_r   <= 1'b0;
                  for (int i = 0; i < 8; i++) begin
                    v_r[i] <= h_r[i];
                  end
                end
              end
              FN_REBOOT: begin
                out_valid_r <= 1'b1;
                if (mode_r != MODE_FINAL) begin
                  out_status_r <= ST_NOT_FINAL;
                end else begin
                  out_swap_r <= 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_ROUND: begin
          v_r[7] <= v_r[6];
          v_r[6] <= v_r[5];
          v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2];
          v_r[2] <= v_r[1];
          v_r[1] <= v_r[0];
          v_r[0] <= t1 + a0 + mj;
          for (int j = 0; j < 15; j++) begin
            blk_r[j] <= blk_r[j+1];
          end
          blk_r[15] <= w_new;
          rnd_r     <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) begin
            state_r <= S_FOLD;
          end
        end
        S_FOLD: begin
          for (int i = 0; i < 8; i++) begin
            h_r[i] <= hsum[i];
          end
          if (second_r) begin
            // length-only block
            for (int j = 0; j < 14; j++) begin
              blk_r[j] <= '0;
            end
            blk_r[14] <= len_bits[63:32];
            blk_r[15] <= len_bits[31:0];
            for (int i = 0; i < 8; i++) begin
              v_r[i] <= hsum[i];
            end
            second_r <= 1'b0;
            rnd_r    <= '0;
            state_r  <= S_ROUND;
          end else if (is_end_r) begin
            state_r <= S_CHECK;
          end else begin
            if (resp_r) begin
              out_valid_r  <= 1'b1;
              out_status_r <= ST_OK;
              out_echo_r   <= resp_echo_r;
              out_swap_r   <= 1'b0;
            end
            resp_r  <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        S_CHECK: begin
          out_valid_r  <= 1'b1;
          out_echo_r   <= '0;
          out_swap_r   <= 1'b0;
          rem_r        <= '0;
          is_end_r     <= 1'b0;
          if (digest_ok) begin
            mode_r       <= MODE_FINAL;
            out_status_r <= ST_OK;
          end else begin
            mode_r       <= MODE_ERROR;
            out_status_r <= ST_DIGEST_MISM;
          end
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/orv_checker.sv
module orv_checker import orv_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  out_status,
  input logic [23:0] out_echo_offset,
  input logic        out_swap_request
);

  // held result keeps its fields
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
    $stable(out_echo_offset) && $stable(out_swap_request))
    else $error("stalled result changed");

  // swap request only with ok status
  a_swap_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_swap_request |-> out_status == ST_OK && out_echo_offset == 24'd0)
    else $error("swap request with error status");

  // echoed offset only with ok status
  a_echo_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_echo_offset != 24'd0 |-> out_status == ST_OK)
    else $error("offset echoed on error");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // stalled result blocks new items
  a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall || !in_valid || in_stall)
    else $error("item taken while result stalled");

endmodule

bind ota_image_receive_verifier_unit orv_checker u_orv_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_status       (out_status),
  .out_echo_offset  (out_echo_offset),
  .out_swap_request (out_swap_request)
);
